/* sv/rsrb_pkg.sv */
package rsrb_pkg;

    // field widths
    localparam int unsigned ID_W     = 32;
    localparam int unsigned FIRST_W  = 9;
    localparam int unsigned SECOND_W = 10;
    localparam int unsigned TOTAL_W  = 10;
    localparam int unsigned BAND_W   = 2;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned CFG_IDX_W = 2;

    // packed stream widths, whole bytes
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 64;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - ID_W - FIRST_W - SECOND_W - TOTAL_W;

    // results per set are capped here
    localparam int unsigned OUT_LIMIT = 16;
    localparam int unsigned RANK_W    = $clog2(OUT_LIMIT);

    // saturation limit of the total
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXCELLENT_END = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_END      = 2'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] EXCELLENT_END_RST = 5'd1;
    localparam logic [CFG_W-1:0] PASS_END_RST      = 5'd5;

    // rank band codes
    localparam logic [BAND_W-1:0] BAND_EXCELLENT = 2'd0;
    localparam logic [BAND_W-1:0] BAND_PASS      = 2'd1;
    localparam logic [BAND_W-1:0] BAND_FAIL      = 2'd2;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [SECOND_W-1:0] second;
        logic [FIRST_W-1:0]  first;
        logic [ID_W-1:0]     id;
    } t_rec;

    // commands shared by every cell of the chain
    typedef struct packed {
        logic load;
        logic pop;
        logic clear;
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

/* sv/record_sort_rank_bands.sv */
// Sorts a set of scored records into descending order of total score.
// Input channel (i_s_*): one record per item, tlast marks the final record of
// the set. Each record is inserted into a chain of MAX_RECORDS cells as it
// arrives, so an item is taken every cycle while loading; a record arriving
// with the chain full is dropped.
// Output channel (o_m_*): after the item with tlast is accepted, the input
// stalls and the stored records leave best first, one item per cycle while
// tready is high, from the cycle after that acceptance. tlast marks the final
// result, tuser holds the rank band (excellent, pass, fail) set by the two band
// boundaries. At most 16 results leave per set; the chain is then emptied and
// loading resumes in the next cycle. Equal totals keep their arrival order.
// The emit rate is set by the single head cell that feeds the output.
// When the receiver holds tready low, the head result simply waits in the
// chain and nothing is lost.
// Configuration port: index 0 excellent boundary, index 1 pass boundary, always
// ready; the user must write it only while idle, not enforced by the block.
// Reset empties the chain and loads the boundaries with 1 and 5.
module record_sort_rank_bands #(
    parameter int unsigned MAX_RECORDS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input records
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // [31:0] record_id, [40:32] first_score, [50:41] second_score, rest zero
    input  logic [rsrb_pkg::IN_TDATA_W-1:0]        i_s_tdata,
    input  logic                                   i_s_tlast,
    // sorted results
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [31:0] out_id, [40:32] out_first, [50:41] out_second, [60:51] total_score
    output logic [rsrb_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // [1:0] rank_band
    output logic [rsrb_pkg::BAND_W-1:0]            o_m_tuser,
    output logic                                   o_m_tlast,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rsrb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rsrb_pkg::CFG_W-1:0]             i_cfg_data
);

    rsrb_pkg::t_state    r_state;
    rsrb_pkg::t_state    n_state;
    logic [rsrb_pkg::RANK_W-1:0] r_rank;
    logic [rsrb_pkg::RANK_W-1:0] n_rank;
    logic [rsrb_pkg::CFG_W-1:0]  r_excellent_end;
    logic [rsrb_pkg::CFG_W-1:0]  r_pass_end;

    rsrb_pkg::t_cell_ctl ctl;
    rsrb_pkg::t_rec      new_rec;
    rsrb_pkg::t_rec      cell_rec [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] cell_valid;
    logic [MAX_RECORDS-1:0] cell_keep;

    logic [rsrb_pkg::FIRST_W+rsrb_pkg::SECOND_W-1:0] first_ext;
    logic [rsrb_pkg::FIRST_W+rsrb_pkg::SECOND_W-1:0] second_ext;
    logic [rsrb_pkg::FIRST_W+rsrb_pkg::SECOND_W-1:0] sum;

    logic in_acc;
    logic out_acc;
    logic last_res;
    logic [rsrb_pkg::CFG_W-1:0] rank_ext;

    // unpack the incoming record and saturate its total
    assign first_ext  = {{rsrb_pkg::SECOND_W{1'b0}}, i_s_tdata[40:32]};
    assign second_ext = {{rsrb_pkg::FIRST_W{1'b0}}, i_s_tdata[50:41]};
    assign sum        = first_ext + second_ext;

    always_comb begin
        new_rec.id     = i_s_tdata[31:0];
        new_rec.first  = i_s_tdata[40:32];
        new_rec.second = i_s_tdata[50:41];
        if (sum > {{rsrb_pkg::FIRST_W{1'b0}}, rsrb_pkg::TOTAL_MAX}) begin
            new_rec.total = rsrb_pkg::TOTAL_MAX;
        end else begin
            new_rec.total = sum[rsrb_pkg::TOTAL_W-1:0];
        end
    end

    // handshakes
    assign o_s_tready = (r_state == rsrb_pkg::ST_LOAD);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == rsrb_pkg::ST_EMIT) && cell_valid[0];
    assign out_acc    = o_m_tvalid && i_m_tready;
    assign o_cfg_ready = 1'b1;

    // final result: chain runs dry after the head, or the result cap is reached
    assign last_res = !cell_valid[1] || (r_rank == rsrb_pkg::RANK_W'(rsrb_pkg::OUT_LIMIT - 1));

    // chain commands; a full chain drops the new record
    always_comb begin
        ctl.load  = in_acc && !cell_valid[MAX_RECORDS-1];
        ctl.pop   = out_acc && !last_res;
        ctl.clear = out_acc && last_res;
    end

    // chain of insertion cells
    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        rsrb_pkg::t_rec prev_rec;
        rsrb_pkg::t_rec next_rec;
        logic           prev_valid;
        logic           prev_keep;
        logic           next_valid;

        if (g == 0) begin : g_head
            assign prev_rec   = new_rec;
            assign prev_valid = 1'b1;
            assign prev_keep  = 1'b1;
        end else begin : g_body
            assign prev_rec   = cell_rec[g-1];
            assign prev_valid = cell_valid[g-1];
            assign prev_keep  = cell_keep[g-1];
        end

        if (g == MAX_RECORDS - 1) begin : g_tail
            assign next_rec   = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_rec   = cell_rec[g+1];
            assign next_valid = cell_valid[g+1];
        end

        rsrb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new_rec   (new_rec),
            .i_prev_rec  (prev_rec),
            .i_prev_valid(prev_valid),
            .i_prev_keep (prev_keep),
            .i_next_rec  (next_rec),
            .i_next_valid(next_valid),
            .o_rec       (cell_rec[g]),
            .o_valid     (cell_valid[g]),
            .o_keep      (cell_keep[g])
        );
    end

    // load and emit sequencing
    always_comb begin
        n_state = r_state;
        n_rank  = r_rank;
        unique case (r_state)
            rsrb_pkg::ST_LOAD: begin
                n_rank = '0;
                if (in_acc && i_s_tlast) begin
                    n_state = rsrb_pkg::ST_EMIT;
                end
            end
            rsrb_pkg::ST_EMIT: begin
                if (out_acc) begin
                    if (last_res) begin
                        n_state = rsrb_pkg::ST_LOAD;
                        n_rank  = '0;
                    end else begin
                        n_rank = r_rank + 1'b1;
                    end
                end
            end
            default: begin
                n_state = rsrb_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsrb_pkg::ST_LOAD;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_rank  <= n_rank;
        end
    end

    // band boundary registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excellent_end <= rsrb_pkg::EXCELLENT_END_RST;
            r_pass_end      <= rsrb_pkg::PASS_END_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rsrb_pkg::CFG_EXCELLENT_END: r_excellent_end <= i_cfg_data;
                rsrb_pkg::CFG_PASS_END:      r_pass_end      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // rank band of the head result, fail taking precedence
    assign rank_ext = {{(rsrb_pkg::CFG_W - rsrb_pkg::RANK_W){1'b0}}, r_rank};

    always_comb begin
        priority if (rank_ext >= r_pass_end) begin
            o_m_tuser = rsrb_pkg::BAND_FAIL;
        end else if (rank_ext < r_excellent_end) begin
            o_m_tuser = rsrb_pkg::BAND_EXCELLENT;
        end else begin
            o_m_tuser = rsrb_pkg::BAND_PASS;
        end
    end

    // result payload straight from the head cell
    assign o_m_tdata = {{rsrb_pkg::OUT_PAD_W{1'b0}}, cell_rec[0].total, cell_rec[0].second,
                        cell_rec[0].first, cell_rec[0].id};
    assign o_m_tlast = last_res;

endmodule

/* sv/rsrb_cell.sv */
module rsrb_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rsrb_pkg::t_cell_ctl   i_ctl,
    input  rsrb_pkg::t_rec        i_new_rec,
    input  rsrb_pkg::t_rec        i_prev_rec,
    input  logic                  i_prev_valid,
    input  logic                  i_prev_keep,
    input  rsrb_pkg::t_rec        i_next_rec,
    input  logic                  i_next_valid,
    output rsrb_pkg::t_rec        o_rec,
    output logic                  o_valid,
    output logic                  o_keep
);

    rsrb_pkg::t_rec r_rec;
    rsrb_pkg::t_rec n_rec;
    logic           r_valid;
    logic           n_valid;

    // stored record stays ahead of the new one when its total is not lower
    assign o_keep  = r_valid && (r_rec.total >= i_new_rec.total);
    assign o_rec   = r_rec;
    assign o_valid = r_valid;

    // insert, shift towards the head, or clear
    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        priority if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.pop) begin
            n_rec   = i_next_rec;
            n_valid = i_next_valid;
        end else if (i_ctl.load) begin
            if (!o_keep) begin
                n_rec = i_prev_keep ? i_new_rec : i_prev_rec;
            end
            n_valid = r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

/* dv/tb_record_sort_rank_bands.sv */
`timescale 1ns / 1ps

module tb_record_sort_rank_bands;
    import rsrb_pkg::*;

    localparam int unsigned STORE_DEPTH     = 16;
    localparam int unsigned PHASE_COUNT     = 8;
    localparam int unsigned ITEMS_PER_PHASE = 31;
    localparam int unsigned HANG_LIMIT      = 2000;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned TAIL_CYCLES     = 40;

    // expected sorted results with their rank bands
    class rank_scoreboard;
        typedef struct packed {
            t_rec              rec;
            logic [BAND_W-1:0] band;
            logic              last;
        } t_ranked;

        t_rec           sorted_set[$];
        t_ranked        ranked_due[$];
        logic [CFG_W-1:0] excellent_end;
        logic [CFG_W-1:0] pass_end;
        int unsigned    mismatches;

        function new();
            excellent_end = EXCELLENT_END_RST;
            pass_end      = PASS_END_RST;
            mismatches    = 0;
        endfunction

        function void set_boundary(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_EXCELLENT_END: excellent_end = val;
                CFG_PASS_END:      pass_end = val;
                default: ;
            endcase
        endfunction

        function logic [BAND_W-1:0] band_for(int unsigned rank);
            if (rank >= pass_end)
                return BAND_FAIL;
            if (rank < excellent_end)
                return BAND_EXCELLENT;
            return BAND_PASS;
        endfunction

        // insert behind every equal or better total unless full, emit the set on the last item
        function void note_record(logic [ID_W-1:0] id, logic [FIRST_W-1:0] first,
                                  logic [SECOND_W-1:0] second, logic last);
            t_rec        r;
            t_ranked     res;
            logic [10:0] sum;
            int unsigned pos;
            int unsigned n;
            sum = {2'b00, first} + {1'b0, second};
            r.id     = id;
            r.first  = first;
            r.second = second;
            r.total  = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (sorted_set.size() < STORE_DEPTH) begin
                pos = 0;
                while (pos < sorted_set.size() && sorted_set[pos].total >= r.total)
                    pos++;
                sorted_set.insert(pos, r);
            end
            if (last) begin
                n = (sorted_set.size() > OUT_LIMIT) ? OUT_LIMIT : sorted_set.size();
                for (int unsigned i = 0; i < n; i++) begin
                    res.rec  = sorted_set[i];
                    res.band = band_for(i);
                    res.last = (i + 1 == n);
                    ranked_due.push_back(res);
                end
                sorted_set.delete();
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [BAND_W-1:0] tuser,
                          logic tlast);
            t_ranked want;
            t_rec    got;
            if (ranked_due.size() == 0) begin
                report("unexpected result id", tdata[ID_W-1:0], 0);
                return;
            end
            want = ranked_due.pop_front();
            got  = tdata[ID_W+FIRST_W+SECOND_W+TOTAL_W-1:0];
            if (got.id !== want.rec.id)
                report("out_id", got.id, want.rec.id);
            if (got.first !== want.rec.first)
                report("out_first", got.first, want.rec.first);
            if (got.second !== want.rec.second)
                report("out_second", got.second, want.rec.second);
            if (got.total !== want.rec.total)
                report("total_score", got.total, want.rec.total);
            if (tuser !== want.band)
                report("rank_band", tuser, want.band);
            if (tlast !== want.last)
                report("last_out", tlast, want.last);
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata = '0;
    logic                    i_s_tlast = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic [BAND_W-1:0]       o_m_tuser;
    logic                    o_m_tlast;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    rank_scoreboard sb = new();
    int unsigned    src_idle_pct = 0;
    int unsigned    snk_stall_pct = 0;
    int unsigned    quiet_cycles = 0;

    record_sort_rank_bands #(
        .MAX_RECORDS(STORE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // handshakes are sampled mid-cycle, clear of the driving edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // hang detection: cycles with no item moving on any channel
    always @(negedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == HANG_LIMIT) begin
            $display("timeout after %0d quiet cycles", HANG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one record item, with random sender gaps ahead of it
    task automatic send_record(logic [ID_W-1:0] id, logic [FIRST_W-1:0] first,
                               logic [SECOND_W-1:0] second, logic last);
        logic taken;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - ID_W - FIRST_W - SECOND_W){1'b0}}, second, first, id};
        i_s_tlast  <= last;
        do begin
            @(negedge i_clk);
            taken = o_s_tready;
            if (taken)
                sb.note_record(id, first, second, last);
            @(posedge i_clk);
        end while (!taken);
    endtask

    // sender holds off until every sorted result has left
    task automatic wait_results_done();
        i_s_tvalid <= 1'b0;
        while (sb.ranked_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        logic taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            if (taken)
                sb.set_boundary(idx, val);
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic set_bands(logic [CFG_W-1:0] exc, logic [CFG_W-1:0] pas);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_EXCELLENT_END, exc);
        write_reg(CFG_PASS_END, pas);
        i_cfg_valid <= 1'b0;
    endtask

    // band boundaries per phase, phase 0 runs on the reset values
    int unsigned phase_exc  [PHASE_COUNT] = '{1, 0, 16, 31, 3, 2, 0, 16};
    int unsigned phase_pass [PHASE_COUNT] = '{5, 0, 16, 31, 2, 12, 16, 0};
    // full chain with ties and saturated totals, then a dropped last record
    int unsigned dir_first  [16] = '{0, 511, 400, 100, 200, 300, 511, 1,
                                     256, 0, 150, 150, 399, 2, 128, 0};
    int unsigned dir_second [16] = '{0, 1023, 600, 200, 100, 0, 600, 0,
                                     512, 1023, 150, 150, 600, 1, 256, 300};

    initial begin
        int unsigned         sent;
        int unsigned         set_len;
        int unsigned         roll;
        logic                tie_heavy;
        logic [ID_W-1:0]     id;
        logic [FIRST_W-1:0]  first;
        logic [SECOND_W-1:0] second;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sets
        for (int unsigned k = 0; k < 16; k++) begin
            id = (k == 0) ? '0 : (k == 1) ? '1 : $urandom;
            send_record(id, FIRST_W'(dir_first[k]), SECOND_W'(dir_second[k]), 1'b0);
        end
        send_record(32'h5A5A_A5A5, 9'd511, 10'd1023, 1'b1);
        send_record(32'hFFFF_FFFF, 9'd400, 10'd600, 1'b1);
        send_record(32'h0000_0001, 9'd0, 10'd0, 1'b0);
        send_record(32'h0000_0002, 9'd0, 10'd0, 1'b1);

        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            if (p != 0)
                set_bands(CFG_W'(phase_exc[p]), CFG_W'(phase_pass[p]));
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
                default: begin src_idle_pct = 32; snk_stall_pct = 32; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                roll = $urandom_range(99);
                if (roll < 10)
                    set_len = $urandom_range(20, 17);
                else if (roll < 25)
                    set_len = $urandom_range(2, 1);
                else
                    set_len = $urandom_range(16, 3);
                tie_heavy = ($urandom_range(3) == 0);
                for (int unsigned k = 0; k < set_len; k++) begin
                    if (tie_heavy) begin
                        first  = FIRST_W'(100 * $urandom_range(4));
                        second = SECOND_W'(100 * $urandom_range(6));
                    end else if ($urandom_range(3) == 0) begin
                        first  = FIRST_W'($urandom_range(511));
                        second = SECOND_W'($urandom_range(1023));
                    end else begin
                        first  = FIRST_W'($urandom_range(400));
                        second = SECOND_W'($urandom_range(600));
                    end
                    send_record($urandom, first, second, k + 1 == set_len);
                end
                sent += set_len;
                if ($urandom_range(4) == 0)
                    wait_results_done();
            end
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.ranked_due.size() != 0)
            sb.report("results never seen", sb.ranked_due.size(), 0);
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
